/* design/chsp_pkg.sv */
// Shared types and constants for the CIFF header stream parser.
// Used by the front classifier, the command queue, the back end and the top level.
`default_nettype none

package chsp_pkg;

    // Byte offsets that end each fixed header field.
    localparam int unsigned MAGIC_END    = 4;
    localparam int unsigned HDRSIZE_END  = 12;
    localparam int unsigned CONTSIZE_END = 20;
    localparam int unsigned WIDTH_END    = 28;
    localparam int unsigned HDR_MIN      = 36;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Command queue between the front and the back end.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Verdict codes reported on the final byte.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_MAGIC    = 3'd2;
    localparam logic [2:0] ST_HDRSIZE  = 3'd3;
    localparam logic [2:0] ST_TOTAL    = 3'd4;
    localparam logic [2:0] ST_CONTENT  = 3'd5;
    localparam logic [2:0] ST_CAPTION  = 3'd6;
    localparam logic [2:0] ST_TAGS     = 3'd7;

    typedef enum logic [3:0] {
        SEC_MAGIC    = 4'd0,
        SEC_HDRSIZE  = 4'd1,
        SEC_CONTSIZE = 4'd2,
        SEC_WIDTH    = 4'd3,
        SEC_HEIGHT   = 4'd4,
        SEC_CAPTION  = 4'd5,
        SEC_CAP_NL   = 4'd6,
        SEC_TAG      = 4'd7,
        SEC_TAG_NUL  = 4'd8,
        SEC_PIXEL    = 4'd9
    } t_section;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  section;
        logic [7:0]  byte_out;
        logic        file_done;
        logic [2:0]  status;
        logic [63:0] image_width;
        logic [63:0] image_height;
    } t_out_item;

    // One classified byte as handed from the front to the back end.
    typedef struct packed {
        t_section   section;
        logic [7:0] data;
        logic       eof;
        logic [2:0] lane;
        logic [2:0] pre_status;
        logic [2:0] late_status;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // Expected magic "CIFF", one character per position.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = 8'h43;
            2'd1: r = 8'h49;
            2'd2: r = 8'h46;
            2'd3: r = 8'h46;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/chsp_front.sv */
// Front part: accepts file bytes, tracks the byte index and header fields,
// labels each byte and forms the verdict ranks that do not need the product. Uses chsp_pkg.
`default_nettype none

module chsp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire chsp_pkg::t_in_item i_item,
    input  wire logic               i_full,
    output chsp_pkg::t_push         o_push
);

    logic [63:0] r_count, n_count;
    logic [63:0] r_len, n_len;
    logic [63:0] r_header_len, n_header_len;
    logic [63:0] r_content_len, n_content_len;
    logic [63:0] r_sum;
    logic        r_caption_closed, n_caption_closed;
    logic        r_magic_err, n_magic_err;
    logic        r_tag_err, n_tag_err;

    logic             accept;
    logic             c_hi_zero;
    logic [5:0]       c_lo;
    logic [2:0]       lane;
    logic [7:0]       b;
    logic             is_short;
    logic             hdr_bad;
    chsp_pkg::t_cmd   cmd;

    assign accept = i_valid && !i_full;
    assign b      = i_item.data_byte;

    // Classify the byte, assemble header fields and form the verdict ranks.
    always_comb begin
        n_count          = r_count;
        n_len            = r_len;
        n_header_len     = r_header_len;
        n_content_len    = r_content_len;
        n_caption_closed = r_caption_closed;
        n_magic_err      = r_magic_err;
        n_tag_err        = r_tag_err;

        c_hi_zero = (r_count[63:6] == 58'd0);
        c_lo      = r_count[5:0];
        // Every size field starts at an offset of 4 modulo 8.
        lane      = r_count[2:0] ^ 3'b100;

        cmd             = '0;
        cmd.data        = b;
        cmd.eof         = i_item.end_of_file;
        cmd.lane        = lane;
        cmd.section     = chsp_pkg::SEC_PIXEL;
        cmd.pre_status  = chsp_pkg::ST_OK;
        cmd.late_status = chsp_pkg::ST_OK;

        if (c_hi_zero && c_lo < 6'(chsp_pkg::MAGIC_END)) begin
            cmd.section = chsp_pkg::SEC_MAGIC;
            if (b != chsp_pkg::magic_byte(r_count[1:0])) begin
                n_magic_err = 1'b1;
            end
        end else if (c_hi_zero && c_lo < 6'(chsp_pkg::HDRSIZE_END)) begin
            cmd.section = chsp_pkg::SEC_HDRSIZE;
            n_header_len[{lane, 3'b000} +: 8] = b;
        end else if (c_hi_zero && c_lo < 6'(chsp_pkg::CONTSIZE_END)) begin
            cmd.section = chsp_pkg::SEC_CONTSIZE;
            n_content_len[{lane, 3'b000} +: 8] = b;
        end else if (c_hi_zero && c_lo < 6'(chsp_pkg::WIDTH_END)) begin
            cmd.section = chsp_pkg::SEC_WIDTH;
        end else if (c_hi_zero && c_lo < 6'(chsp_pkg::HDR_MIN)) begin
            cmd.section = chsp_pkg::SEC_HEIGHT;
        end else if (r_count < r_header_len) begin
            if (!r_caption_closed) begin
                if (b == chsp_pkg::CHAR_NEWLINE) begin
                    cmd.section      = chsp_pkg::SEC_CAP_NL;
                    n_caption_closed = 1'b1;
                end else begin
                    cmd.section = chsp_pkg::SEC_CAPTION;
                end
            end else begin
                cmd.section = (b == chsp_pkg::CHAR_NUL) ? chsp_pkg::SEC_TAG_NUL
                                                        : chsp_pkg::SEC_TAG;
                // The last header byte is the one whose count equals the header size.
                if (r_len == r_header_len && b != chsp_pkg::CHAR_NUL) begin
                    n_tag_err = 1'b1;
                end
            end
        end

        // Byte index saturates at the top of its range.
        if (r_count != '1) begin
            n_count = r_count + 64'd1;
            n_len   = (r_len == '1) ? r_len : r_len + 64'd1;
        end

        // Verdict ranks known here; the content check is done in the back end.
        is_short = (r_len[63:6] == 58'd0) && (r_len[5:0] < 6'(chsp_pkg::HDR_MIN));
        hdr_bad  = (r_header_len < 64'(chsp_pkg::HDR_MIN)) || (r_header_len > r_len);
        if (i_item.end_of_file) begin
            if (is_short) begin
                cmd.pre_status = chsp_pkg::ST_SHORT;
            end else if (n_magic_err) begin
                cmd.pre_status = chsp_pkg::ST_MAGIC;
            end else if (hdr_bad) begin
                cmd.pre_status = chsp_pkg::ST_HDRSIZE;
            end else if (r_sum != r_len) begin
                cmd.pre_status = chsp_pkg::ST_TOTAL;
            end
            if (r_header_len > 64'(chsp_pkg::HDR_MIN) && !n_caption_closed) begin
                cmd.late_status = chsp_pkg::ST_CAPTION;
            end else if (n_tag_err) begin
                cmd.late_status = chsp_pkg::ST_TAGS;
            end
        end
    end

    assign o_push.valid = accept;
    assign o_push.cmd   = cmd;

    // File state; everything returns to its reset value after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count          <= '0;
            r_len            <= 64'd1;
            r_header_len     <= '0;
            r_content_len    <= '0;
            r_caption_closed <= 1'b0;
            r_magic_err      <= 1'b0;
            r_tag_err        <= 1'b0;
        end else if (accept) begin
            if (i_item.end_of_file) begin
                r_count          <= '0;
                r_len            <= 64'd1;
                r_header_len     <= '0;
                r_content_len    <= '0;
                r_caption_closed <= 1'b0;
                r_magic_err      <= 1'b0;
                r_tag_err        <= 1'b0;
            end else begin
                r_count          <= n_count;
                r_len            <= n_len;
                r_header_len     <= n_header_len;
                r_content_len    <= n_content_len;
                r_caption_closed <= n_caption_closed;
                r_magic_err      <= n_magic_err;
                r_tag_err        <= n_tag_err;
            end
        end
    end

    // Size sum for the total check. Both sizes are final long before the
    // first byte at which a file can pass the length test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= r_header_len + r_content_len;
        end
    end

endmodule

`default_nettype wire

/* design/chsp_queue.sv */
// Short command queue that decouples the front from the back end.
// Uses chsp_pkg for the command type and depth.
`default_nettype none

module chsp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire chsp_pkg::t_push i_push,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output chsp_pkg::t_cmd       o_cmd
);

    chsp_pkg::t_cmd                  r_mem [chsp_pkg::QUEUE_DEPTH];
    logic [chsp_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [chsp_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [chsp_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == chsp_pkg::QCNT_W'(chsp_pkg::QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + chsp_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + chsp_pkg::QPTR_W'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_cnt <= r_cnt + chsp_pkg::QCNT_W'(1);
            end else if (!i_push.valid && do_pop) begin
                r_cnt <= r_cnt - chsp_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* design/chsp_back.sv */
// Back end: assembles width, height and content size, forms 3*width*height
// byte by byte, settles the final verdict and holds the output register. Uses chsp_pkg.
`default_nettype none

module chsp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire chsp_pkg::t_cmd   i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output chsp_pkg::t_out_item   o_out_item
);

    typedef struct packed {
        chsp_pkg::t_section section;
        logic [7:0]         data;
        logic               eof;
        logic [2:0]         lane;
        logic [2:0]         pre_status;
        logic [2:0]         late_status;
        logic [73:0]        partial;
        logic [63:0]        width;
        logic [63:0]        height;
        logic [63:0]        content;
    } t_mul_stage;

    typedef struct packed {
        chsp_pkg::t_section section;
        logic [7:0]         data;
        logic               eof;
        logic [2:0]         pre_status;
        logic [2:0]         late_status;
        logic [63:0]        width;
        logic [63:0]        height;
        logic [63:0]        content;
        logic [129:0]       acc;
    } t_acc_stage;

    // Per-file state.
    logic [63:0]  r_width, n_width;
    logic [63:0]  r_height, n_height;
    logic [63:0]  r_content, n_content;
    logic [65:0]  r_w3, n_w3;
    logic [129:0] r_acc, n_acc;

    logic         r_m_valid, r_a_valid, r_v_valid;
    t_mul_stage   r_m;
    t_acc_stage   r_a;
    chsp_pkg::t_out_item r_v;

    logic         en_m, en_a, en_v;
    logic [9:0]   trip;
    logic [73:0]  partial;
    logic         mismatch;
    chsp_pkg::t_out_item v_item;

    // Stages advance whenever the next one is free or moving.
    assign en_v  = !r_v_valid || !i_out_stall;
    assign en_a  = !r_a_valid || en_v;
    assign en_m  = !r_m_valid || en_a;
    assign o_pop = i_q_valid && en_m;

    // Field assembly; three times the width is built up alongside the width.
    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_content = r_content;
        n_w3      = r_w3;
        partial   = '0;
        trip      = {2'b00, i_cmd.data} + {1'b0, i_cmd.data, 1'b0};
        if (i_cmd.section == chsp_pkg::SEC_CONTSIZE) begin
            n_content[{i_cmd.lane, 3'b000} +: 8] = i_cmd.data;
        end
        if (i_cmd.section == chsp_pkg::SEC_WIDTH) begin
            n_width[{i_cmd.lane, 3'b000} +: 8] = i_cmd.data;
            n_w3 = r_w3 + (66'(trip) << {i_cmd.lane, 3'b000});
        end
        if (i_cmd.section == chsp_pkg::SEC_HEIGHT) begin
            n_height[{i_cmd.lane, 3'b000} +: 8] = i_cmd.data;
            partial = {8'd0, r_w3} * {66'd0, i_cmd.data};
        end
    end

    // Multiply stage control and file state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_width   <= '0;
            r_height  <= '0;
            r_content <= '0;
            r_w3      <= '0;
        end else if (en_m) begin
            r_m_valid <= i_q_valid;
            if (i_q_valid) begin
                if (i_cmd.eof) begin
                    r_width   <= '0;
                    r_height  <= '0;
                    r_content <= '0;
                    r_w3      <= '0;
                end else begin
                    r_width   <= n_width;
                    r_height  <= n_height;
                    r_content <= n_content;
                    r_w3      <= n_w3;
                end
            end
        end
    end

    // Multiply stage payload.
    always_ff @(posedge i_clk) begin
        if (en_m && i_q_valid) begin
            r_m.section     <= i_cmd.section;
            r_m.data        <= i_cmd.data;
            r_m.eof         <= i_cmd.eof;
            r_m.lane        <= i_cmd.lane;
            r_m.pre_status  <= i_cmd.pre_status;
            r_m.late_status <= i_cmd.late_status;
            r_m.partial     <= partial;
            r_m.width       <= n_width;
            r_m.height      <= n_height;
            r_m.content     <= n_content;
        end
    end

    // Product accumulation, one height byte a step.
    assign n_acc = r_acc + (130'(r_m.partial) << {r_m.lane, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_acc     <= '0;
        end else if (en_a) begin
            r_a_valid <= r_m_valid;
            if (r_m_valid) begin
                r_acc <= r_m.eof ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && r_m_valid) begin
            r_a.section     <= r_m.section;
            r_a.data        <= r_m.data;
            r_a.eof         <= r_m.eof;
            r_a.pre_status  <= r_m.pre_status;
            r_a.late_status <= r_m.late_status;
            r_a.width       <= r_m.width;
            r_a.height      <= r_m.height;
            r_a.content     <= r_m.content;
            r_a.acc         <= n_acc;
        end
    end

    // Final verdict: the front ranks first, then the content check, then caption and tags.
    always_comb begin
        mismatch            = (r_a.acc != {66'd0, r_a.content});
        v_item              = '0;
        v_item.section      = r_a.section;
        v_item.byte_out     = r_a.data;
        v_item.file_done    = r_a.eof;
        if (r_a.eof) begin
            v_item.image_width  = r_a.width;
            v_item.image_height = r_a.height;
            if (r_a.pre_status != chsp_pkg::ST_OK) begin
                v_item.status = r_a.pre_status;
            end else if (mismatch) begin
                v_item.status = chsp_pkg::ST_CONTENT;
            end else begin
                v_item.status = r_a.late_status;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else if (en_v) begin
            r_v_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_v && r_a_valid) begin
            r_v <= v_item;
        end
    end

    assign o_out_valid = r_v_valid;
    assign o_out_item  = r_v;

endmodule

`default_nettype wire

/* design/ciff_header_stream_parser_unit.sv */
// CIFF header stream parser, top level: one result item per byte item.
// After its item is accepted, a result passes the queue write, the multiply
// stage, the accumulate stage and the output register. Throughput: one item
// per cycle unless the output stalls; the product of 3*width and height takes
// one 66x8 multiply and one accumulate per height byte. Synchronous
// active-low reset clears all file state at once; there is no clearing pass.
`default_nettype none

module ciff_header_stream_parser_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire chsp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output chsp_pkg::t_out_item      o_out_item
);

    chsp_pkg::t_push q_push;
    chsp_pkg::t_cmd  q_cmd;
    logic            q_valid;
    logic            q_full;
    logic            q_pop;

    assign o_in_stall = q_full;

    // Byte classification and header tracking.
    chsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_push  (q_push)
    );

    // Command queue between the two sides.
    chsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    // Product, verdict and output register.
    chsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
